@@ hw/rtl/zstd_pkg.sv @@
// zstd_pkg: shared types, codes and tables for the text word decoder
// no dependencies; imported by every module of the decoder

package zstd_pkg;

	localparam int unsigned MAX_WORDS       = 31;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [6:0]  MAX_CHARS_RST   = 7'd47;
	localparam logic [6:0]  CHAR_SPACE      = 7'd32;
	localparam logic [6:0]  CHAR_TILDE_NEXT = 7'd127;
	localparam logic [6:0]  UPPER_OFFSET    = 7'd59;
	localparam logic [6:0]  LOWER_OFFSET    = 7'd91;
	localparam int unsigned RESULTS_MAX     = 4;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_ABBR = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_ABBR_EN   = 1'b0,
		REG_MAX_CHARS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] code;
	} result_t;

	typedef struct packed {
		logic [2:0]                     count;
		result_t [RESULTS_MAX-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [6:0] punct_char(input logic [4:0] idx);
		logic [6:0] ch;
		case (idx)
			5'd0:  ch = 7'd0;
			5'd1:  ch = 7'd10;
			5'd2:  ch = 7'h30;
			5'd3:  ch = 7'h31;
			5'd4:  ch = 7'h32;
			5'd5:  ch = 7'h33;
			5'd6:  ch = 7'h34;
			5'd7:  ch = 7'h35;
			5'd8:  ch = 7'h36;
			5'd9:  ch = 7'h37;
			5'd10: ch = 7'h38;
			5'd11: ch = 7'h39;
			5'd12: ch = 7'h2e;
			5'd13: ch = 7'h2c;
			5'd14: ch = 7'h21;
			5'd15: ch = 7'h3f;
			5'd16: ch = 7'h5f;
			5'd17: ch = 7'h23;
			5'd18: ch = 7'h27;
			5'd19: ch = 7'h22;
			5'd20: ch = 7'h2f;
			5'd21: ch = 7'h5c;
			5'd22: ch = 7'h2d;
			5'd23: ch = 7'h3a;
			5'd24: ch = 7'h28;
			5'd25: ch = 7'h29;
			default: ch = 7'd0;
		endcase
		return ch;
	endfunction

endpackage

@@ hw/rtl/zstd_front.sv @@
// zstd_front: takes text words, runs the three codes through the shift and
// escape state and packs the word's results into one queue entry; uses zstd_pkg

module zstd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        z_word,
	input  logic               abbr_en,
	input  logic [6:0]         max_chars,
	input  zstd_pkg::q_stat_t  q_stat,
	output logic               push,
	output zstd_pkg::bundle_t  push_data
);
	import zstd_pkg::*;

	typedef enum logic [1:0] {
		ALPHA_LOWER = 2'd0,
		ALPHA_UPPER = 2'd1,
		ALPHA_PUNCT = 2'd2
	} alpha_t;

	typedef enum logic [2:0] {
		PEND_NONE   = 3'd0,
		PEND_ABBR   = 3'd1,
		PEND_ESC_HI = 3'd2,
		PEND_ESC_LO = 3'd3
	} pend_t;

	typedef struct packed {
		logic [1:0] alpha;
		pend_t      pend;
		logic [4:0] esc;
		logic [6:0] cnt;
	} st_t;

	typedef struct packed {
		st_t     st;
		logic    emit;
		result_t res;
	} step_t;

	localparam st_t ST_RST = '{alpha: ALPHA_LOWER, pend: PEND_NONE, esc: 5'd0, cnt: 7'd0};

	function automatic step_t do_code(input st_t s, input logic [4:0] c,
			input logic allow, input logic [6:0] maxc);
		step_t      r;
		logic [9:0] zs;
		logic [6:0] ch;
		logic       want;
		r.st       = s;
		r.emit     = 1'b0;
		r.res.kind = KIND_CHAR;
		r.res.code = 7'd0;
		want       = 1'b0;
		ch         = 7'd0;
		zs         = {s.esc, c};
		case (s.pend)
			PEND_ABBR: begin
				r.st.pend  = PEND_NONE;
				r.emit     = 1'b1;
				r.res.kind = KIND_ABBR;
				r.res.code = {s.esc[1:0] - 2'd1, c};
			end
			PEND_ESC_HI: begin
				r.st.esc  = c;
				r.st.pend = PEND_ESC_LO;
			end
			PEND_ESC_LO: begin
				r.st.pend = PEND_NONE;
				if (zs >= 10'(CHAR_SPACE) && zs < 10'(CHAR_TILDE_NEXT)) begin
					want = 1'b1;
					ch   = zs[6:0];
				end
			end
			default: begin
				r.st.pend = PEND_NONE;
				if (c == 5'd0) begin
					r.st.alpha = ALPHA_LOWER;
					want       = 1'b1;
					ch         = CHAR_SPACE;
				end else if (c <= 5'd3) begin
					r.st.alpha = ALPHA_LOWER;
					if (allow) begin
						r.st.esc  = c;
						r.st.pend = PEND_ABBR;
					end
				end else if (c == 5'd4) begin
					r.st.alpha = ALPHA_UPPER;
				end else if (c == 5'd5) begin
					r.st.alpha = ALPHA_PUNCT;
				end else begin
					r.st.alpha = ALPHA_LOWER;
					case (s.alpha)
						ALPHA_UPPER: begin
							want = 1'b1;
							ch   = 7'(c) + UPPER_OFFSET;
						end
						ALPHA_PUNCT: begin
							if (c == 5'd6) begin
								r.st.pend = PEND_ESC_HI;
							end else begin
								want = 1'b1;
								ch   = punct_char(c - 5'd6);
							end
						end
						default: begin
							want = 1'b1;
							ch   = 7'(c) + LOWER_OFFSET;
						end
					endcase
				end
			end
		endcase
		if (want && s.cnt < maxc) begin
			r.st.cnt   = s.cnt + 7'd1;
			r.emit     = 1'b1;
			r.res.kind = KIND_CHAR;
			r.res.code = ch;
		end
		return r;
	endfunction

	st_t        st_q;
	logic [4:0] wcnt_q;

	step_t      stp0, stp1, stp2;
	logic [4:0] wcnt_next;
	logic       done;
	logic       accept;
	bundle_t    bnd;

	always_comb begin
		stp0 = do_code(st_q,    z_word[14:10], abbr_en, max_chars);
		stp1 = do_code(stp0.st, z_word[9:5],   abbr_en, max_chars);
		stp2 = do_code(stp1.st, z_word[4:0],   abbr_en, max_chars);

		wcnt_next = wcnt_q + 5'd1;
		done      = z_word[15] || (wcnt_next >= 5'(MAX_WORDS));

		bnd = '0;
		if (stp0.emit) begin
			bnd.res[bnd.count[1:0]] = stp0.res;
			bnd.count = bnd.count + 3'd1;
		end
		if (stp1.emit) begin
			bnd.res[bnd.count[1:0]] = stp1.res;
			bnd.count = bnd.count + 3'd1;
		end
		if (stp2.emit) begin
			bnd.res[bnd.count[1:0]] = stp2.res;
			bnd.count = bnd.count + 3'd1;
		end
		if (done) begin
			bnd.res[bnd.count[1:0]].kind = KIND_END;
			bnd.res[bnd.count[1:0]].code = 7'd0;
			bnd.count = bnd.count + 3'd1;
		end
	end

	assign in_stall  = q_stat.full;
	assign accept    = in_valid && !q_stat.full;
	assign push      = accept && (bnd.count != 3'd0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RST;
			wcnt_q <= 5'd0;
		end else if (accept) begin
			if (done) begin
				st_q   <= ST_RST;
				wcnt_q <= 5'd0;
			end else begin
				st_q   <= stp2.st;
				wcnt_q <= wcnt_next;
			end
		end
	end

endmodule

@@ hw/rtl/zstd_queue.sv @@
// zstd_queue: short queue of per-word result bundles between front and back
// uses zstd_pkg

module zstd_queue #(
	parameter int unsigned DEPTH = zstd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  zstd_pkg::bundle_t  push_data,
	input  logic               pop,
	output zstd_pkg::bundle_t  head,
	output zstd_pkg::q_stat_t  stat
);
	import zstd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign stat.full  = (fill_q == CW'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/zstd_back.sv @@
// zstd_back: walks the head bundle one result per cycle into the output register
// while out_stall is low; uses zstd_pkg

module zstd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  zstd_pkg::bundle_t  head,
	input  zstd_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [6:0]         result_code,
	output logic               last_result
);
	import zstd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    res_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = !q_stat.empty && (!valid_q || !out_stall);
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.count;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.res[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign result_kind = res_q.kind;
	assign result_code = res_q.code;
	assign last_result = last_q;

endmodule

@@ hw/rtl/zstring_text_decoder.sv @@
// zstring_text_decoder: top level, configuration registers and the
// front / queue / back chain; uses zstd_pkg, zstd_front, zstd_queue, zstd_back
// a word's first result passes through its queue entry and then the output register before it is valid
// throughput: one result per cycle at the output register while out_stall is low; a word
// has 0 to 4 results; a word is taken every cycle the queue has room
// reset: asynchronous active-low, clears string state, queue and output; registers to defaults

module zstring_text_decoder #(
	parameter int unsigned QUEUE_DEPTH = zstd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] z_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [6:0]  result_code,
	output logic        last_result
);
	import zstd_pkg::*;

	logic       abbr_en_q;
	logic [6:0] max_chars_q;
	reg_idx_t   reg_sel;
	logic       wr_en;

	logic       push;
	bundle_t    push_data;
	bundle_t    head;
	q_stat_t    q_stat;
	logic       pop;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abbr_en_q   <= 1'b0;
			max_chars_q <= MAX_CHARS_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ABBR_EN:   abbr_en_q   <= pwdata[0];
				REG_MAX_CHARS: max_chars_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ABBR_EN:   prdata = {31'd0, abbr_en_q};
			REG_MAX_CHARS: prdata = {25'd0, max_chars_q};
			default:       prdata = 32'd0;
		endcase
	end

	zstd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.z_word     (z_word),
		.abbr_en    (abbr_en_q),
		.max_chars  (max_chars_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	zstd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	zstd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.result_code (result_code),
		.last_result (last_result)
	);

endmodule
